// ----- src/ers_pkg.sv -----
// ----------------------------------------------------------------------------
// ers_pkg : engine run supervisor shared definitions
// Types, constants and configuration register codes used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package ers_pkg;

  // Fixed thresholds and hysteresis bands
  localparam logic [11:0] OverheatHystK   = 12'd20;
  localparam logic [15:0] RevHystRpm      = 16'd200;
  localparam logic [15:0] CrankMaxEntryS  = 16'd20;
  localparam logic [15:0] CrankEndRpm     = 16'd700;
  localparam logic [15:0] InjWdLimitMs    = 16'd200;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_OVERHEAT_LIMIT  = 3'd0,
    CFG_RPM_LIMIT       = 3'd1,
    CFG_LIMP_RPM_LIMIT  = 3'd2,
    CFG_STANDBY_TIMEOUT = 3'd3,
    CFG_SENSOR_OPTIONS  = 3'd4,
    CFG_PRIMING_ENABLE  = 3'd5
  } cfg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic [11:0] overheat_limit_k;
    logic [15:0] rpm_limit;
    logic [15:0] limp_rpm_limit;
    logic [15:0] standby_lim_s;
    logic [4:0]  sensor_options;
  } cfg_regs_t;

  // One tick snapshot
  typedef struct packed {
    logic [5:0]  digital_inputs;
    logic [5:0]  sensor_errors;
    logic [11:0] coolant_temp_k;
    logic [15:0] engine_rpm;
    logic [1:0]  decoder_status;
    logic [31:0] decoder_idle_s;
    logic [15:0] engine_runtime_s;
    logic [15:0] injector1_idle_ms;
    logic [15:0] injector2_idle_ms;
    logic [7:0]  priming_remain_s;
  } in_item_t;

  // Supervisor flags carried from tick to tick
  typedef struct packed {
    logic fatal;
    logic limp;
    logic rev_limit;
    logic overheat;
    logic run_ok;
    logic standby;
    logic cranking;
    logic priming;
    logic pump;
  } sup_state_t;

  // One result transaction
  typedef struct packed {
    logic       run_allowed;
    logic       limp_mode;
    logic       rev_limit_active;
    logic       overheat_active;
    logic       standby_active;
    logic       cranking_active;
    logic       pump_on;
    logic       actors_off;
    logic       fatal_active;
    logic [2:0] halt_reasons;
  } out_item_t;

endpackage

`default_nettype wire

// ----- src/ers_in_if.sv -----
// ----------------------------------------------------------------------------
// ers_in_if : tick snapshot channel
// Valid/ready channel carrying one sensor and decoder snapshot per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ers_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  digital_inputs;
  logic [5:0]  sensor_errors;
  logic [11:0] coolant_temp_k;
  logic [15:0] engine_rpm;
  logic [1:0]  decoder_status;
  logic [31:0] decoder_idle_s;
  logic [15:0] engine_runtime_s;
  logic [15:0] injector1_idle_ms;
  logic [15:0] injector2_idle_ms;
  logic [7:0]  priming_remain_s;

  modport source (
    output valid, digital_inputs, sensor_errors, coolant_temp_k, engine_rpm,
           decoder_status, decoder_idle_s, engine_runtime_s, injector1_idle_ms,
           injector2_idle_ms, priming_remain_s,
    input  ready
  );

  modport sink (
    input  valid, digital_inputs, sensor_errors, coolant_temp_k, engine_rpm,
           decoder_status, decoder_idle_s, engine_runtime_s, injector1_idle_ms,
           injector2_idle_ms, priming_remain_s,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/ers_out_if.sv -----
// ----------------------------------------------------------------------------
// ers_out_if : supervisor result channel
// Valid/ready channel carrying the control flags of one tick per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ers_out_if;
  logic       valid;
  logic       ready;
  logic       run_allowed;
  logic       limp_mode;
  logic       rev_limit_active;
  logic       overheat_active;
  logic       standby_active;
  logic       cranking_active;
  logic       pump_on;
  logic       actors_off;
  logic       fatal_active;
  logic [2:0] halt_reasons;

  modport source (
    output valid, run_allowed, limp_mode, rev_limit_active, overheat_active,
           standby_active, cranking_active, pump_on, actors_off, fatal_active,
           halt_reasons,
    input  ready
  );

  modport sink (
    input  valid, run_allowed, limp_mode, rev_limit_active, overheat_active,
           standby_active, cranking_active, pump_on, actors_off, fatal_active,
           halt_reasons,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/ers_rules.sv -----
// ----------------------------------------------------------------------------
// ers_rules : supervisor rule evaluation
// Applies the supervisor rules to one snapshot in firmware order and returns
// the next flag set and the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ers_rules (
  input  wire ers_pkg::cfg_regs_t  cfg,
  input  wire ers_pkg::sup_state_t cur,
  input  wire ers_pkg::in_item_t   item,
  output ers_pkg::sup_state_t nxt,
  output ers_pkg::out_item_t  res
);

  logic        run_on, crash_lvl, side_lvl, in_gear, service, ext_fatal;
  logic        tps_err, map_err, gear_err, speed_valid, standstill;
  logic        inj_overrun;
  logic [15:0] max_rpm;
  logic [15:0] rev_release;
  logic [11:0] oh_release;
  logic        run_off, crash_trig, side_trig;
  logic        crank_set, crank_clr;

  // Decode snapshot bits
  assign run_on      = item.digital_inputs[0];
  assign crash_lvl   = item.digital_inputs[1];
  assign side_lvl    = item.digital_inputs[2];
  assign in_gear     = item.digital_inputs[3];
  assign service     = item.digital_inputs[4];
  assign ext_fatal   = item.digital_inputs[5];
  assign tps_err     = item.sensor_errors[0];
  assign map_err     = item.sensor_errors[1];
  assign gear_err    = item.sensor_errors[5];
  assign speed_valid = item.decoder_status[0];
  assign standstill  = item.decoder_status[1];

  assign inj_overrun = (item.injector1_idle_ms > ers_pkg::InjWdLimitMs) ||
                       (item.injector2_idle_ms > ers_pkg::InjWdLimitMs);

  // Halt reasons, evaluated every tick
  assign run_off    = !run_on;
  assign crash_trig = (crash_lvl == cfg.sensor_options[0]);
  assign side_trig  = (side_lvl == cfg.sensor_options[1]) && in_gear && !gear_err;

  // Release thresholds, floored at zero
  assign oh_release = (cfg.overheat_limit_k > ers_pkg::OverheatHystK) ?
                      (cfg.overheat_limit_k - ers_pkg::OverheatHystK) : 12'd0;

  always_comb begin
    nxt = cur;

    // Fatal latch
    if ((inj_overrun && !service) || ext_fatal) begin
      nxt.fatal = 1'b1;
    end

    // Limp latch, judged with the previous run allow
    if (!cur.limp && !nxt.fatal && cur.run_ok && (item.sensor_errors[4:0] != 5'd0)) begin
      nxt.limp = 1'b1;
    end

    // Rev limiter with hysteresis
    max_rpm     = nxt.limp ? cfg.limp_rpm_limit : cfg.rpm_limit;
    rev_release = (max_rpm > ers_pkg::RevHystRpm) ? (max_rpm - ers_pkg::RevHystRpm) : 16'd0;
    if (speed_valid && (item.engine_rpm > max_rpm)) begin
      nxt.rev_limit = 1'b1;
    end else if (!speed_valid || (cur.rev_limit && (item.engine_rpm < rev_release))) begin
      nxt.rev_limit = 1'b0;
    end

    // Overheat and run allow
    if (nxt.fatal) begin
      nxt.run_ok = 1'b0;
    end else begin
      if (item.coolant_temp_k > cfg.overheat_limit_k) begin
        nxt.overheat = 1'b1;
      end else if (cur.overheat && (item.coolant_temp_k < oh_release)) begin
        nxt.overheat = 1'b0;
      end
      nxt.run_ok = (!run_off || cfg.sensor_options[2]) &&
                   (!crash_trig || cfg.sensor_options[3]) &&
                   (!side_trig || cfg.sensor_options[4]) &&
                   !nxt.overheat && !nxt.rev_limit && !service &&
                   (!map_err || !tps_err);
    end

    // Standby on decoder timeout
    nxt.standby = (item.decoder_idle_s > {16'd0, cfg.standby_lim_s}) && nxt.run_ok;

    // Cranking: clear wins over set, rpm at the end mark holds
    crank_set = nxt.run_ok && (item.engine_runtime_s < ers_pkg::CrankMaxEntryS) &&
                !nxt.standby && !standstill && (item.engine_rpm < ers_pkg::CrankEndRpm);
    crank_clr = (speed_valid && (item.engine_rpm > ers_pkg::CrankEndRpm)) ||
                !nxt.run_ok || nxt.standby || standstill;
    if (crank_clr) begin
      nxt.cranking = 1'b0;
    end else if (crank_set) begin
      nxt.cranking = 1'b1;
    end

    // Fuel pump and priming
    if (nxt.fatal) begin
      nxt.pump = 1'b0;
    end else begin
      if (cur.priming && (item.priming_remain_s == 8'd0)) begin
        nxt.priming = 1'b0;
      end
      if (!service) begin
        nxt.pump = (!nxt.standby && nxt.run_ok) || nxt.priming;
      end
    end
  end

  // Result transaction
  always_comb begin
    res.run_allowed      = nxt.run_ok;
    res.limp_mode        = nxt.limp;
    res.rev_limit_active = nxt.rev_limit;
    res.overheat_active  = nxt.overheat;
    res.standby_active   = nxt.standby;
    res.cranking_active  = nxt.cranking;
    res.pump_on          = nxt.pump;
    res.actors_off       = nxt.fatal || (!service && (nxt.standby || !nxt.run_ok));
    res.fatal_active     = nxt.fatal;
    res.halt_reasons     = {side_trig, crash_trig, run_off};
  end

endmodule

`default_nettype wire

// ----- src/engine_run_supervisor_core.sv -----
// ----------------------------------------------------------------------------
// engine_run_supervisor_core : engine run supervisor
// Usage:
//   in_chan carries one 10 ms tick snapshot per transaction (sensor levels,
//   error bits, coolant temperature, decoder and watchdog data). out_chan
//   returns exactly one result transaction per tick: run allow, limp, rev
//   limiter, overheat, standby, cranking, pump, actors-off, fatal and the
//   halt reasons.
//   The tick sits in the input register while the rule logic settles; the
//   result register and the flag state then load together when the tick
//   advances. Throughput is one tick per cycle while out_chan.ready stays
//   high; the rule logic between the two registers is combinational.
//   The cfg_ port writes one register per cycle (index, data) and must be
//   used only while the block is idle; the block itself does not enforce
//   this. Writing the priming enable also reloads the priming flag unless a tick advances in the same cycle.
//   Synchronous active-low reset loads the register defaults and the flag
//   reset values (standby and priming set, all else clear) and empties both
//   registers. When the receiver stalls, the result is held and one more
//   tick is taken into the input register; then in_chan.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module engine_run_supervisor_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ers_in_if.sink                             in_chan,
  ers_out_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [ers_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [ers_pkg::CfgDataW-1:0]  cfg_wdata
);

  ers_pkg::cfg_regs_t  cfg_r;
  ers_pkg::sup_state_t state_r;
  ers_pkg::sup_state_t state_nxt;
  ers_pkg::in_item_t   in_pl_r;
  ers_pkg::in_item_t   in_pl_nxt;
  ers_pkg::out_item_t  out_pl_r;
  ers_pkg::out_item_t  res;
  logic                in_vld_r;
  logic                out_vld_r;
  logic                in_take;
  logic                advance;

  // Handshake: advance when the result register is free or being drained
  assign advance        = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready  = !in_vld_r || advance;
  assign in_take        = in_chan.valid && in_chan.ready;

  // Snapshot gathered from the channel
  always_comb begin
    in_pl_nxt.digital_inputs    = in_chan.digital_inputs;
    in_pl_nxt.sensor_errors     = in_chan.sensor_errors;
    in_pl_nxt.coolant_temp_k    = in_chan.coolant_temp_k;
    in_pl_nxt.engine_rpm        = in_chan.engine_rpm;
    in_pl_nxt.decoder_status    = in_chan.decoder_status;
    in_pl_nxt.decoder_idle_s    = in_chan.decoder_idle_s;
    in_pl_nxt.engine_runtime_s  = in_chan.engine_runtime_s;
    in_pl_nxt.injector1_idle_ms = in_chan.injector1_idle_ms;
    in_pl_nxt.injector2_idle_ms = in_chan.injector2_idle_ms;
    in_pl_nxt.priming_remain_s  = in_chan.priming_remain_s;
  end

  // Rule evaluation
  ers_rules u_rules (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (in_pl_r),
    .nxt  (state_nxt),
    .res  (res)
  );

  // Input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_pl_r <= in_pl_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_pl_r <= res;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.overheat_limit_k <= 12'd380;
      cfg_r.rpm_limit        <= 16'd9000;
      cfg_r.limp_rpm_limit   <= 16'd4000;
      cfg_r.standby_lim_s    <= 16'd2;
      cfg_r.sensor_options   <= 5'd0;
    end else if (cfg_we) begin
      case (ers_pkg::cfg_idx_t'(cfg_index))
        ers_pkg::CFG_OVERHEAT_LIMIT:  cfg_r.overheat_limit_k <= cfg_wdata[11:0];
        ers_pkg::CFG_RPM_LIMIT:       cfg_r.rpm_limit        <= cfg_wdata;
        ers_pkg::CFG_LIMP_RPM_LIMIT:  cfg_r.limp_rpm_limit   <= cfg_wdata;
        ers_pkg::CFG_STANDBY_TIMEOUT: cfg_r.standby_lim_s    <= cfg_wdata;
        ers_pkg::CFG_SENSOR_OPTIONS:  cfg_r.sensor_options   <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  // Supervisor flags: updated per tick, priming reloaded on its register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{fatal: 1'b0, limp: 1'b0, rev_limit: 1'b0, overheat: 1'b0,
                   run_ok: 1'b0, standby: 1'b1, cranking: 1'b0,
                   priming: 1'b1, pump: 1'b0};
    end else if (advance) begin
      state_r <= state_nxt;
    end else if (cfg_we && (ers_pkg::cfg_idx_t'(cfg_index) == ers_pkg::CFG_PRIMING_ENABLE)) begin
      state_r.priming <= cfg_wdata[0];
    end
  end

  // Result channel
  assign out_chan.valid            = out_vld_r;
  assign out_chan.run_allowed      = out_pl_r.run_allowed;
  assign out_chan.limp_mode        = out_pl_r.limp_mode;
  assign out_chan.rev_limit_active = out_pl_r.rev_limit_active;
  assign out_chan.overheat_active  = out_pl_r.overheat_active;
  assign out_chan.standby_active   = out_pl_r.standby_active;
  assign out_chan.cranking_active  = out_pl_r.cranking_active;
  assign out_chan.pump_on          = out_pl_r.pump_on;
  assign out_chan.actors_off       = out_pl_r.actors_off;
  assign out_chan.fatal_active     = out_pl_r.fatal_active;
  assign out_chan.halt_reasons     = out_pl_r.halt_reasons;

endmodule

`default_nettype wire

// ----- bench/tb_engine_run_supervisor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_engine_run_supervisor_core : self-checking bench for the run supervisor
// Streams tick snapshots into the block with random gaps on both channels and
// compares every result transaction against a cycle-free model of the rules.
// Configuration changes happen only after the pipeline has drained. The run
// latches limited operation late, and the fatal latch only at the very end.
// ----------------------------------------------------------------------------
module tb_engine_run_supervisor_core;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned QuietLimit   = 1000;

  // Work list for the tick driver
  typedef enum logic [1:0] {
    STEP_TICK,
    STEP_CFG,
    STEP_SETTLE
  } step_kind_t;

  typedef struct packed {
    step_kind_t                   kind;
    ers_pkg::cfg_idx_t            idx;
    logic [ers_pkg::CfgDataW-1:0] wdata;
    ers_pkg::in_item_t            tick;
  } plan_step_t;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         cfg_we    = 1'b0;
  ers_pkg::cfg_idx_t            cfg_index = ers_pkg::CFG_OVERHEAT_LIMIT;
  logic [ers_pkg::CfgDataW-1:0] cfg_wdata = '0;

  ers_in_if  tick_if ();
  ers_out_if flag_if ();

  engine_run_supervisor_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (tick_if),
    .out_chan  (flag_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Model state: register copy and the flags carried between ticks
  ers_pkg::cfg_regs_t  live_cfg;
  ers_pkg::sup_state_t sup;
  ers_pkg::out_item_t  flags_due[$];
  plan_step_t          pending_steps[$];
  int unsigned         mismatches = 0;

  // Register values as planned at queue-fill time, used to shape stimulus
  logic [11:0] plan_clt_lim;
  logic [15:0] plan_rpm_lim;
  logic [15:0] plan_limp_lim;
  logic [15:0] plan_timeout;
  logic [4:0]  plan_opts;

  // Handshake flags seen at the last rising edge
  logic        tick_fire = 1'b0;
  logic        flag_fire = 1'b0;
  int unsigned quiet     = 0;

  int unsigned tick_gap    = 0;
  int unsigned tick_calm   = 0;
  int unsigned flag_stall  = 0;
  int unsigned flag_calm   = 0;
  int unsigned settle_wait = 0;

  function automatic int unsigned floor_sub(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones; calm runs have none
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [31:0] near(input longint center, input int unsigned spread,
                                       input longint top);
    longint v;
    v = center + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v[31:0];
  endfunction

  // One supervisor tick, rules in firmware order
  task automatic step_supervisor(input ers_pkg::in_item_t t, output ers_pkg::out_item_t r);
    logic        run_off;
    logic        crash_trig;
    logic        side_trig;
    logic        service;
    logic        speed_valid;
    logic        standstill;
    logic [15:0] rev_lim;
    service     = t.digital_inputs[4];
    speed_valid = t.decoder_status[0];
    standstill  = t.decoder_status[1];

    // sticky fatal: injector watchdog outside service, or external fatal
    if (((t.injector1_idle_ms > ers_pkg::InjWdLimitMs ||
          t.injector2_idle_ms > ers_pkg::InjWdLimitMs) &&
         !service) || t.digital_inputs[5])
      sup.fatal = 1'b1;

    // limp latch uses the run allow of the previous tick
    if (!sup.limp && !sup.fatal && sup.run_ok && t.sensor_errors[4:0] != '0)
      sup.limp = 1'b1;

    // rev limiter with hysteresis
    rev_lim = sup.limp ? live_cfg.limp_rpm_limit : live_cfg.rpm_limit;
    if (speed_valid && t.engine_rpm > rev_lim)
      sup.rev_limit = 1'b1;
    else if (!speed_valid ||
             (sup.rev_limit && t.engine_rpm < floor_sub(rev_lim, ers_pkg::RevHystRpm)))
      sup.rev_limit = 1'b0;

    // halt reasons, also evaluated while fatal
    run_off    = !t.digital_inputs[0];
    crash_trig = (t.digital_inputs[1] == live_cfg.sensor_options[0]);
    side_trig  = (t.digital_inputs[2] == live_cfg.sensor_options[1]) &&
                 t.digital_inputs[3] && !t.sensor_errors[5];

    // overheat and run allow
    if (sup.fatal) begin
      sup.run_ok = 1'b0;
    end else begin
      if (t.coolant_temp_k > live_cfg.overheat_limit_k)
        sup.overheat = 1'b1;
      else if (sup.overheat &&
               t.coolant_temp_k < floor_sub(live_cfg.overheat_limit_k,
                                            ers_pkg::OverheatHystK))
        sup.overheat = 1'b0;
      sup.run_ok = (!run_off || live_cfg.sensor_options[2]) &&
                   (!crash_trig || live_cfg.sensor_options[3]) &&
                   (!side_trig || live_cfg.sensor_options[4]) &&
                   !sup.overheat && !sup.rev_limit && !service &&
                   !(t.sensor_errors[1] && t.sensor_errors[0]);
    end

    sup.standby = (t.decoder_idle_s > live_cfg.standby_lim_s) && sup.run_ok;

    // cranking: set, then clear; exactly at the end speed it holds
    if (sup.run_ok && t.engine_runtime_s < ers_pkg::CrankMaxEntryS && !sup.standby &&
        !standstill && t.engine_rpm < ers_pkg::CrankEndRpm)
      sup.cranking = 1'b1;
    if ((speed_valid && t.engine_rpm > ers_pkg::CrankEndRpm) || !sup.run_ok ||
        sup.standby || standstill)
      sup.cranking = 1'b0;

    // fuel pump and priming; service mode holds the pump
    if (sup.fatal) begin
      sup.pump = 1'b0;
    end else begin
      if (sup.priming && t.priming_remain_s == '0) sup.priming = 1'b0;
      if (!service) sup.pump = (!sup.standby && sup.run_ok) || sup.priming;
    end

    r.run_allowed      = sup.run_ok;
    r.limp_mode        = sup.limp;
    r.rev_limit_active = sup.rev_limit;
    r.overheat_active  = sup.overheat;
    r.standby_active   = sup.standby;
    r.cranking_active  = sup.cranking;
    r.pump_on          = sup.pump;
    r.actors_off       = sup.fatal || (!service && (sup.standby || !sup.run_ok));
    r.fatal_active     = sup.fatal;
    r.halt_reasons     = {side_trig, crash_trig, run_off};
  endtask

  task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Stimulus shapes
  function automatic ers_pkg::in_item_t raw_tick();
    ers_pkg::in_item_t t;
    t.digital_inputs    = 6'($urandom);
    t.sensor_errors     = 6'($urandom);
    t.coolant_temp_k    = 12'($urandom);
    t.engine_rpm        = 16'($urandom);
    t.decoder_status    = 2'($urandom);
    t.decoder_idle_s    = $urandom;
    t.engine_runtime_s  = 16'($urandom);
    t.injector1_idle_ms = 16'($urandom);
    t.injector2_idle_ms = 16'($urandom);
    t.priming_remain_s  = 8'($urandom);
    return t;
  endfunction

  // Snapshot of a healthy engine about to crank under the planned options
  function automatic ers_pkg::in_item_t clean_tick();
    ers_pkg::in_item_t t;
    t = '0;
    t.digital_inputs[0] = 1'b1;
    t.digital_inputs[1] = !plan_opts[0];
    t.digital_inputs[2] = !plan_opts[1];
    t.coolant_temp_k    = 12'd300;
    t.engine_rpm        = 16'd300;
    t.decoder_status    = 2'b01;
    t.priming_remain_s  = 8'd5;
    return t;
  endfunction

  // Mostly run-ready ticks with values around the thresholds, the rest noise
  function automatic ers_pkg::in_item_t shaped_tick(input bit errs_ok, input bit fatal_ok);
    ers_pkg::in_item_t t;
    t = raw_tick();
    if ($urandom_range(0, 9) < 8) begin
      t.digital_inputs[0] = ($urandom_range(0, 15) != 0);
      t.digital_inputs[1] = plan_opts[0] ^ ($urandom_range(0, 9) != 0);
      t.digital_inputs[3] = ($urandom_range(0, 3) == 0);
      t.digital_inputs[4] = ($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 3) != 0) t.sensor_errors = '0;
      t.coolant_temp_k = 12'(near(plan_clt_lim, 30, 4095));
      case ($urandom_range(0, 3))
        0:       t.engine_rpm = 16'(near(plan_rpm_lim, 250, 65535));
        1:       t.engine_rpm = 16'(near(plan_limp_lim, 250, 65535));
        2:       t.engine_rpm = 16'(near(ers_pkg::CrankEndRpm, 40, 65535));
        default: t.engine_rpm = 16'($urandom_range(0, 3000));
      endcase
      if ($urandom_range(0, 4) != 0) t.decoder_status = 2'b01;
      if ($urandom_range(0, 3) != 0) t.decoder_idle_s = near(plan_timeout, 3, 32'hFFFF_FFFF);
      if ($urandom_range(0, 3) != 0)
        t.engine_runtime_s = 16'(near(ers_pkg::CrankMaxEntryS, 6, 65535));
      if ($urandom_range(0, 1) != 0) t.priming_remain_s = 8'($urandom_range(0, 2));
      t.injector1_idle_ms = 16'($urandom_range(0, 210));
      t.injector2_idle_ms = 16'($urandom_range(0, 210));
    end
    // keep the fatal latch closed until the final stretch
    if (!fatal_ok) begin
      t.digital_inputs[5] = 1'b0;
      if (!t.digital_inputs[4]) begin
        if (t.injector1_idle_ms > ers_pkg::InjWdLimitMs)
          t.injector1_idle_ms = ers_pkg::InjWdLimitMs;
        if (t.injector2_idle_ms > ers_pkg::InjWdLimitMs)
          t.injector2_idle_ms = ers_pkg::InjWdLimitMs;
      end
    end
    if (!errs_ok) t.sensor_errors[4:0] = '0;
    return t;
  endfunction

  task automatic add_tick(input ers_pkg::in_item_t t);
    plan_step_t s;
    s      = '0;
    s.kind = STEP_TICK;
    s.tick = t;
    pending_steps.push_back(s);
  endtask

  // Drain the pipeline, then write every register
  task automatic add_settings(input logic [11:0] clt_lim, input logic [15:0] rpm_lim,
                              input logic [15:0] limp_lim, input logic [15:0] timeout,
                              input logic [4:0] opts, input logic prime);
    plan_step_t s;
    s      = '0;
    s.kind = STEP_SETTLE;
    pending_steps.push_back(s);
    s.kind  = STEP_CFG;
    s.idx   = ers_pkg::CFG_OVERHEAT_LIMIT;
    s.wdata = 16'(clt_lim);
    pending_steps.push_back(s);
    s.idx   = ers_pkg::CFG_RPM_LIMIT;
    s.wdata = rpm_lim;
    pending_steps.push_back(s);
    s.idx   = ers_pkg::CFG_LIMP_RPM_LIMIT;
    s.wdata = limp_lim;
    pending_steps.push_back(s);
    s.idx   = ers_pkg::CFG_STANDBY_TIMEOUT;
    s.wdata = timeout;
    pending_steps.push_back(s);
    s.idx   = ers_pkg::CFG_SENSOR_OPTIONS;
    s.wdata = 16'(opts);
    pending_steps.push_back(s);
    s.idx   = ers_pkg::CFG_PRIMING_ENABLE;
    s.wdata = 16'(prime);
    pending_steps.push_back(s);
    plan_clt_lim  = clt_lim;
    plan_rpm_lim  = rpm_lim;
    plan_limp_lim = limp_lim;
    plan_timeout  = timeout;
    plan_opts     = opts;
  endtask

  // Monitor: config shadow, result check, tick prediction, watchdog
  always @(posedge clk) begin
    ers_pkg::out_item_t want;
    ers_pkg::out_item_t got;
    ers_pkg::out_item_t pred;
    if (rst_n) begin
      tick_fire = tick_if.valid && tick_if.ready;
      flag_fire = flag_if.valid && flag_if.ready;

      if (cfg_we) begin
        case (cfg_index)
          ers_pkg::CFG_OVERHEAT_LIMIT:  live_cfg.overheat_limit_k = cfg_wdata[11:0];
          ers_pkg::CFG_RPM_LIMIT:       live_cfg.rpm_limit        = cfg_wdata;
          ers_pkg::CFG_LIMP_RPM_LIMIT:  live_cfg.limp_rpm_limit   = cfg_wdata;
          ers_pkg::CFG_STANDBY_TIMEOUT: live_cfg.standby_lim_s    = cfg_wdata;
          ers_pkg::CFG_SENSOR_OPTIONS:  live_cfg.sensor_options   = cfg_wdata[4:0];
          ers_pkg::CFG_PRIMING_ENABLE:  sup.priming               = cfg_wdata[0];
          default: ;
        endcase
      end

      // result transaction against the oldest prediction
      if (flag_fire) begin
        got = {flag_if.run_allowed, flag_if.limp_mode, flag_if.rev_limit_active,
               flag_if.overheat_active, flag_if.standby_active, flag_if.cranking_active,
               flag_if.pump_on, flag_if.actors_off, flag_if.fatal_active,
               flag_if.halt_reasons};
        if (flags_due.size() == 0) begin
          $error("result transaction with no tick outstanding");
          mismatches++;
        end else begin
          want = flags_due.pop_front();
          check_field("run_allowed", 3'(want.run_allowed), 3'(got.run_allowed));
          check_field("limp_mode", 3'(want.limp_mode), 3'(got.limp_mode));
          check_field("rev_limit_active", 3'(want.rev_limit_active),
                      3'(got.rev_limit_active));
          check_field("overheat_active", 3'(want.overheat_active), 3'(got.overheat_active));
          check_field("standby_active", 3'(want.standby_active), 3'(got.standby_active));
          check_field("cranking_active", 3'(want.cranking_active), 3'(got.cranking_active));
          check_field("pump_on", 3'(want.pump_on), 3'(got.pump_on));
          check_field("actors_off", 3'(want.actors_off), 3'(got.actors_off));
          check_field("fatal_active", 3'(want.fatal_active), 3'(got.fatal_active));
          check_field("halt_reasons", want.halt_reasons, got.halt_reasons);
        end
      end

      // accepted tick transaction
      if (tick_fire) begin
        step_supervisor({tick_if.digital_inputs, tick_if.sensor_errors, tick_if.coolant_temp_k,
                         tick_if.engine_rpm, tick_if.decoder_status, tick_if.decoder_idle_s,
                         tick_if.engine_runtime_s, tick_if.injector1_idle_ms,
                         tick_if.injector2_idle_ms, tick_if.priming_remain_s}, pred);
        flags_due.push_back(pred);
      end

      // watchdog on handshake silence
      if (tick_fire || flag_fire || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Driver: tick source, config writes and result-side stalls
  always @(negedge clk) begin
    plan_step_t head;
    logic       nxt_valid;
    logic       nxt_we;
    if (rst_n) begin
      nxt_valid = tick_if.valid;
      nxt_we    = 1'b0;
      if (tick_fire) begin
        void'(pending_steps.pop_front());
        nxt_valid = 1'b0;
      end

      if (!nxt_valid && tick_gap > 0) begin
        tick_gap--;
      end else if (!nxt_valid && pending_steps.size() > 0) begin
        head = pending_steps[0];
        case (head.kind)
          STEP_TICK: begin
            nxt_valid = 1'b1;
            {tick_if.digital_inputs, tick_if.sensor_errors, tick_if.coolant_temp_k,
             tick_if.engine_rpm, tick_if.decoder_status, tick_if.decoder_idle_s,
             tick_if.engine_runtime_s, tick_if.injector1_idle_ms,
             tick_if.injector2_idle_ms, tick_if.priming_remain_s} = head.tick;
            tick_gap = pick_gap(tick_calm);
          end
          STEP_CFG: begin
            nxt_we    = 1'b1;
            cfg_index = head.idx;
            cfg_wdata = head.wdata;
            void'(pending_steps.pop_front());
          end
          default: begin
            // hold off until every result is back, then let the settle counter run out
            if (flags_due.size() != 0) begin
              settle_wait = 0;
            end else if (settle_wait < SettleCycles) begin
              settle_wait++;
            end else begin
              settle_wait = 0;
              void'(pending_steps.pop_front());
            end
          end
        endcase
      end
      tick_if.valid = nxt_valid;
      cfg_we        = nxt_we;

      // receiver back-pressure
      if (flag_fire || (flag_stall == 0 && $urandom_range(0, 15) == 0))
        flag_stall = pick_gap(flag_calm);
      if (flag_stall > 0) begin
        flag_if.ready = 1'b0;
        flag_stall--;
      end else begin
        flag_if.ready = 1'b1;
      end
    end
  end

  // Reset, stimulus plan and end of run
  initial begin
    ers_pkg::in_item_t t;
    tick_if.valid = 1'b0;
    {tick_if.digital_inputs, tick_if.sensor_errors, tick_if.coolant_temp_k,
     tick_if.engine_rpm, tick_if.decoder_status, tick_if.decoder_idle_s,
     tick_if.engine_runtime_s, tick_if.injector1_idle_ms,
     tick_if.injector2_idle_ms, tick_if.priming_remain_s} = '0;
    flag_if.ready = 1'b0;

    // register and flag values after reset
    live_cfg.overheat_limit_k = 12'd380;
    live_cfg.rpm_limit        = 16'd9000;
    live_cfg.limp_rpm_limit   = 16'd4000;
    live_cfg.standby_lim_s    = 16'd2;
    live_cfg.sensor_options   = 5'd0;
    sup         = '0;
    sup.standby = 1'b1;
    sup.priming = 1'b1;
    plan_clt_lim  = live_cfg.overheat_limit_k;
    plan_rpm_lim  = live_cfg.rpm_limit;
    plan_limp_lim = live_cfg.limp_rpm_limit;
    plan_timeout  = live_cfg.standby_lim_s;
    plan_opts     = live_cfg.sensor_options;

    // directed ticks under the reset configuration
    add_tick('0);
    t = clean_tick();
    add_tick(t);
    t.engine_rpm = ers_pkg::CrankEndRpm;                 // at end speed: cranking holds
    add_tick(t);
    t.engine_rpm = ers_pkg::CrankEndRpm + 16'd1;
    add_tick(t);
    t.engine_rpm = ers_pkg::CrankEndRpm;
    add_tick(t);
    t.engine_rpm = 16'hFFFF;                             // rev limiter engages
    add_tick(t);
    t.engine_rpm = plan_rpm_lim - ers_pkg::RevHystRpm;   // inside hysteresis band
    add_tick(t);
    t.engine_rpm = plan_rpm_lim - ers_pkg::RevHystRpm - 16'd1;
    add_tick(t);
    t = clean_tick();
    t.coolant_temp_k = plan_clt_lim + 12'd1;             // overheat engages
    add_tick(t);
    t.coolant_temp_k = plan_clt_lim - ers_pkg::OverheatHystK;
    add_tick(t);
    t.coolant_temp_k = plan_clt_lim - ers_pkg::OverheatHystK - 12'd1;
    add_tick(t);
    t.coolant_temp_k = 12'hFFF;
    add_tick(t);
    t.coolant_temp_k = 12'd0;
    add_tick(t);
    t = clean_tick();
    t.decoder_idle_s = 32'(plan_timeout) + 32'd1;        // standby
    add_tick(t);
    t.decoder_idle_s = 32'hFFFF_FFFF;
    add_tick(t);
    t.decoder_idle_s = 32'(plan_timeout);
    add_tick(t);
    t = clean_tick();
    t.digital_inputs[4] = 1'b1;                          // service mode masks the watchdog
    t.injector1_idle_ms = 16'hFFFF;
    t.injector2_idle_ms = 16'hFFFF;
    add_tick(t);
    t = clean_tick();
    t.injector1_idle_ms = ers_pkg::InjWdLimitMs;
    t.injector2_idle_ms = ers_pkg::InjWdLimitMs;
    add_tick(t);
    t = clean_tick();
    t.priming_remain_s = 8'd0;                           // priming ends
    add_tick(t);
    t = clean_tick();
    t.digital_inputs[3] = 1'b1;                          // sidestand down in gear
    t.digital_inputs[2] = plan_opts[1];
    add_tick(t);
    t.sensor_errors[5] = 1'b1;                           // gear sensor error masks it
    add_tick(t);
    t = clean_tick();
    t.decoder_status = 2'b10;
    add_tick(t);
    t.decoder_status = 2'b00;
    add_tick(t);
    t = clean_tick();
    t.engine_runtime_s = ers_pkg::CrankMaxEntryS;
    add_tick(t);

    // random phases; limited operation is latched at the start of phase six
    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 6) begin
        add_settings(12'd380, 16'd9000, 16'd4000, 16'd2, 5'd0, 1'b1);
        repeat (3) add_tick(clean_tick());
        t = clean_tick();
        t.sensor_errors = 6'b000001 << $urandom_range(0, 4);
        add_tick(t);
        t = clean_tick();
        t.sensor_errors = 6'b000011;                     // TPS and MAP together block run
        add_tick(t);
      end
      if (ph == 0)
        add_settings(12'd380, 16'd9000, 16'd4000, 16'd2, 5'($urandom), 1'b1);
      else if (ph == 1 || ph == 7)
        add_settings('0, '0, '0, '0, '0, 1'b0);
      else if (ph == 2 || ph == 8)
        add_settings(12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'h1F, 1'b1);
      else
        add_settings(12'($urandom_range(250, 450)), 16'($urandom_range(1000, 12000)),
                     16'($urandom_range(500, 6000)), 16'($urandom_range(0, 10)),
                     5'($urandom), 1'($urandom));
      repeat ((ph < 6) ? 120 : 130) add_tick(shaped_tick(ph >= 6, 1'b0));
    end

    // fatal latch last: it holds until reset
    t = clean_tick();
    case ($urandom_range(0, 2))
      0:       t.injector1_idle_ms = ers_pkg::InjWdLimitMs + 16'd1;
      1:       t.injector2_idle_ms = ers_pkg::InjWdLimitMs + 16'd1;
      default: t.digital_inputs[5] = 1'b1;
    endcase
    add_tick(t);
    repeat (40) add_tick(shaped_tick(1'b1, 1'b1));

    // reset, then let the driver run the plan
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_steps.size() != 0 || flags_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && flags_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
